### hw/rtl/dlnt_pkg.sv
// Shared types, codes and helpers for the doubly linked node table.
`default_nettype none
package dlnt_pkg;

	localparam int unsigned DEPTH     = 64;
	localparam int unsigned IDX_W     = $clog2(DEPTH);
	localparam int unsigned NODE_W    = 7;
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned NODES_DEF = 64;
	localparam int unsigned QDEPTH    = 2;

	localparam logic [CMD_W-1:0] CMD_SPLIT_SUCC = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SPLIT_PRED = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LINK       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_VISIT_SUCC = 3'd3;
	localparam logic [CMD_W-1:0] CMD_VISIT_PRED = 3'd4;

	typedef enum logic [2:0] {
		OP_REJECT  = 3'd0,
		OP_ECHO    = 3'd1,
		OP_SPLIT_S = 3'd2,
		OP_SPLIT_P = 3'd3,
		OP_LINK    = 3'd4,
		OP_VISIT_S = 3'd5,
		OP_VISIT_P = 3'd6
	} op_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [NODE_W-1:0] node;
		logic              last;
	} rsp_t;

	typedef struct packed {
		op_t               op;
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
	} op_item_t;

	function automatic logic in_range(input logic [NODE_W-1:0] v, input int unsigned nodes);
		return (v != '0) && (32'(v) <= nodes);
	endfunction

	function automatic logic [IDX_W-1:0] idx_of(input logic [NODE_W-1:0] v);
		logic [NODE_W-1:0] t;
		t = v - NODE_W'(1);
		return t[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

### hw/rtl/dlnt_front.sv
// Front stage: accepts command items and classifies them into operations.
`default_nettype none
module dlnt_front import dlnt_pkg::*; #(
	parameter int unsigned NODES = NODES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  req_t     req,
	output logic     push_valid,
	input  logic     push_ready,
	output op_item_t push_item
);

	logic     s1_valid_q;
	op_item_t item_s1;
	op_item_t cls;
	logic     a_ok;
	logic     b_ok;
	logic     advance;

	always_comb begin
		a_ok   = in_range(req.node_a, NODES);
		b_ok   = in_range(req.node_b, NODES);
		cls.a  = req.node_a;
		cls.b  = req.node_b;
		unique case (req.cmd)
			CMD_SPLIT_SUCC: cls.op = a_ok ? OP_SPLIT_S : OP_REJECT;
			CMD_SPLIT_PRED: cls.op = a_ok ? OP_SPLIT_P : OP_REJECT;
			CMD_LINK:       cls.op = (a_ok && b_ok) ? OP_LINK : OP_REJECT;
			CMD_VISIT_SUCC: cls.op = a_ok ? OP_VISIT_S : OP_ECHO;
			CMD_VISIT_PRED: cls.op = a_ok ? OP_VISIT_P : OP_ECHO;
			default:        cls.op = OP_REJECT;
		endcase
	end

	assign advance    = !s1_valid_q || push_ready;
	assign req_stall  = !advance;
	assign push_valid = s1_valid_q;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid) begin
			item_s1 <= cls;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/dlnt_queue.sv
// Short queue of classified operations between front and back.
`default_nettype none
module dlnt_queue import dlnt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  op_item_t push_item,
	output logic     pop_valid,
	input  logic     pop_ready,
	output op_item_t pop_item
);

	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	op_item_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = cnt_q != QCNT_W'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");
	a_pop_moves_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> cnt_q == $past(cnt_q) - QCNT_W'(1))
		else $error("pop did not drain queue");
	a_push_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> pop_valid)
		else $error("pushed item not visible");
`endif

endmodule
`default_nettype wire

### hw/rtl/dlnt_back.sv
// Back stage: link tables and the sequencer that carries out split, link and visit.
`default_nettype none
module dlnt_back import dlnt_pkg::*; #(
	parameter int unsigned NODES = NODES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pop_valid,
	output logic     pop_ready,
	input  op_item_t pop_item,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rsp_t     rsp
);

	localparam int unsigned CNT_W = $clog2(NODES + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DONE  = 5'b00010,
		ST_SPLIT = 5'b00100,
		ST_LINK  = 5'b01000,
		ST_WALK  = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	op_t               op_q;
	logic [NODE_W-1:0] a_q, b_q, cur_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [NODE_W-1:0] succ_mem [DEPTH];
	logic [NODE_W-1:0] pred_mem [DEPTH];
	logic [DEPTH-1:0]  succ_v_q, pred_v_q;
	logic [NODE_W-1:0] succ_rd_q, pred_rd_q;
	logic              succ_rv_q, pred_rv_q;

	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              out_free, out_load;
	rsp_t              out_d;
	logic              rd_en, advance;
	logic [IDX_W-1:0]  succ_raddr, pred_raddr;
	logic [IDX_W-1:0]  a_idx, b_idx;
	logic [NODE_W-1:0] succ_y, pred_y, y, nxt;
	logic              link_ok, stop, wr_link;
	logic              clr_succ_en, clr_pred_en;
	logic [IDX_W-1:0]  clr_succ_idx, clr_pred_idx;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign succ_y   = succ_rv_q ? succ_rd_q : '0;
	assign pred_y   = pred_rv_q ? pred_rd_q : '0;
	assign a_idx    = idx_of(a_q);
	assign b_idx    = idx_of(b_q);
	assign y        = (op_q == OP_SPLIT_S) ? succ_y : pred_y;
	assign nxt      = (op_q == OP_VISIT_S) ? succ_y : pred_y;
	assign link_ok  = (succ_y == '0) && (pred_y == '0);
	// stop on no node, on a node out of range, on return to start, or once NODES results are out
	assign stop     = (nxt == '0) || (nxt == a_q) || !in_range(nxt, NODES)
		|| (cnt_q >= CNT_W'(NODES));

	always_comb begin
		state_d      = state_q;
		pop_ready    = 1'b0;
		rd_en        = 1'b0;
		advance      = 1'b0;
		succ_raddr   = idx_of(pop_item.a);
		pred_raddr   = idx_of((pop_item.op == OP_LINK) ? pop_item.b : pop_item.a);
		out_load     = 1'b0;
		out_d        = '0;
		wr_link      = 1'b0;
		clr_succ_en  = 1'b0;
		clr_pred_en  = 1'b0;
		clr_succ_idx = a_idx;
		clr_pred_idx = a_idx;
		unique case (state_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					rd_en = 1'b1;
					unique case (pop_item.op) inside
						OP_REJECT, OP_ECHO:     state_d = ST_DONE;
						OP_SPLIT_S, OP_SPLIT_P: state_d = ST_SPLIT;
						OP_LINK:                state_d = ST_LINK;
						OP_VISIT_S, OP_VISIT_P: state_d = ST_WALK;
						default:                state_d = ST_DONE;
					endcase
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_d.ok   = (op_q == OP_ECHO);
					out_d.node = (op_q == OP_ECHO) ? a_q : '0;
					out_d.last = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SPLIT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_d.ok   = (y != '0);
					out_d.last = 1'b1;
					state_d    = ST_IDLE;
					if (y != '0) begin
						clr_succ_en = 1'b1;
						clr_pred_en = 1'b1;
						// the far end of the cut link loses its opposite pointer
						if (op_q == OP_SPLIT_S) begin
							clr_pred_idx = idx_of(y);
						end else begin
							clr_succ_idx = idx_of(y);
						end
					end
				end
			end
			ST_LINK: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_d.ok   = link_ok;
					out_d.last = 1'b1;
					wr_link    = link_ok;
					state_d    = ST_IDLE;
				end
			end
			ST_WALK: begin
				// emit the held node once the next one is known, so last is exact
				if (out_free) begin
					out_load   = 1'b1;
					out_d.ok   = 1'b1;
					out_d.node = cur_q;
					out_d.last = stop;
					if (stop) begin
						state_d = ST_IDLE;
					end else begin
						advance    = 1'b1;
						rd_en      = 1'b1;
						succ_raddr = idx_of(nxt);
						pred_raddr = idx_of(nxt);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			succ_v_q <= '0;
			pred_v_q <= '0;
		end else begin
			if (wr_link) begin
				succ_v_q[a_idx] <= 1'b1;
				pred_v_q[b_idx] <= 1'b1;
			end
			if (clr_succ_en) begin
				succ_v_q[clr_succ_idx] <= 1'b0;
			end
			if (clr_pred_en) begin
				pred_v_q[clr_pred_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_link) begin
			succ_mem[a_idx] <= b_q;
			pred_mem[b_idx] <= a_q;
		end
		if (rd_en) begin
			succ_rd_q <= succ_mem[succ_raddr];
			pred_rd_q <= pred_mem[pred_raddr];
			succ_rv_q <= succ_v_q[succ_raddr];
			pred_rv_q <= pred_v_q[pred_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			op_q  <= pop_item.op;
			a_q   <= pop_item.a;
			b_q   <= pop_item.b;
			cur_q <= pop_item.a;
			cnt_q <= CNT_W'(1);
		end else if (advance) begin
			cur_q <= nxt;
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (out_load) begin
			rsp_q <= out_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> (cnt_q != '0) && (cnt_q <= CNT_W'(NODES)))
		else $error("walk count out of bounds");
	a_link_sets: assert property (@(posedge clk) disable iff (!arst_n)
		wr_link |=> succ_v_q[$past(a_idx)] && pred_v_q[$past(b_idx)])
		else $error("link did not mark both entries");
	a_nonlast_walk: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !out_d.last |-> state_q == ST_WALK)
		else $error("non-final result outside a visit");
	a_split_clears: assert property (@(posedge clk) disable iff (!arst_n)
		clr_succ_en && (op_q == OP_SPLIT_S) |=> !succ_v_q[$past(a_idx)])
		else $error("split left successor in place");
`endif

endmodule
`default_nettype wire

### hw/rtl/doubly_linked_node_table.sv
// A split, link or rejected item is taken in idle; its result is formed in its split, link
// or done state and registered. The back takes no new item until this one is done; a visit
// does one registered table read per cycle of the walk while the output is not stalled.
// A two-entry queue lets the front take new items while the back is busy or stalled.
// Reset: both link tables read as empty at once through per-entry valid flip-flops.
`default_nettype none
module doubly_linked_node_table import dlnt_pkg::*; #(
	parameter int unsigned NODES = NODES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic     push_valid, push_ready;
	op_item_t push_item;
	logic     pop_valid, pop_ready;
	op_item_t pop_item;

	dlnt_front #(.NODES(NODES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	dlnt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	dlnt_back #(.NODES(NODES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
